// ----- src/slm_pkg.sv -----
// ----------------------------------------------------------------------------
// slm_pkg: shared definitions for the sorted list merger
// Operation codes, field widths, parameter defaults and the store write strobes.
// ----------------------------------------------------------------------------
package slm_pkg;

    localparam int LIST_DEPTH_DEF  = 32;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int OP_W   = 3;
    localparam int DATA_W = 32;

    localparam logic [OP_W-1:0] OP_APPEND_A  = 3'd0;
    localparam logic [OP_W-1:0] OP_APPEND_B  = 3'd1;
    localparam logic [OP_W-1:0] OP_MERGE_ASC = 3'd2;
    localparam logic [OP_W-1:0] OP_MERGE_DSC = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd4;

    typedef struct packed {
        logic we_a;
        logic we_b;
    } slm_wr_t;

endpackage

// ----- src/slm_list_mem.sv -----
// ----------------------------------------------------------------------------
// slm_list_mem: list store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module slm_list_mem
    import slm_pkg::*;
#(
    parameter int DEPTH = LIST_DEPTH_DEF,
    parameter int WIDTH = VALUE_WIDTH_DEF,
    parameter int IDX_W = 5
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- src/slm_merge_ctrl.sv -----
// ----------------------------------------------------------------------------
// slm_merge_ctrl: sequencer of the sorted list merger
// Keeps the counts and the overflow flag, runs the compare pass that records
// which list each merged value comes from, then replays that record forwards
// or backwards into the output register.
// ----------------------------------------------------------------------------
module slm_merge_ctrl
    import slm_pkg::*;
#(
    parameter int LIST_DEPTH  = LIST_DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int IDX_W       = 5
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [DATA_W-1:0]      s_tdata,
    input  logic [OP_W-1:0]        s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [DATA_W-1:0]      m_tdata,
    output logic                   m_tlast,
    output logic [1:0]             m_tuser,
    output slm_wr_t                wr_strobe,
    output logic [IDX_W-1:0]       wr_addr,
    output logic [VALUE_WIDTH-1:0] wr_data,
    output logic [IDX_W-1:0]       rd_addr_a,
    output logic [IDX_W-1:0]       rd_addr_b,
    input  logic [VALUE_WIDTH-1:0] rd_data_a,
    input  logic [VALUE_WIDTH-1:0] rd_data_b
);

    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
    localparam int STEP_W = $clog2(2 * LIST_DEPTH + 1);
    localparam int PICK_W = $clog2(2 * LIST_DEPTH);
    localparam int PICKS  = 2 * LIST_DEPTH;

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_SCAN_RD  = 5'b00010,
        ST_SCAN_CMP = 5'b00100,
        ST_EMIT_RD  = 5'b01000,
        ST_EMIT_OUT = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     cnt_a_reg, cnt_a_next;
    logic [CNT_W-1:0]     cnt_b_reg, cnt_b_next;
    logic                 ovf_reg, ovf_next;
    logic [CNT_W-1:0]     ia_reg, ia_next;
    logic [CNT_W-1:0]     ib_reg, ib_next;
    logic [STEP_W-1:0]    k_reg, k_next;
    logic [STEP_W-1:0]    n_reg, n_next;
    logic                 pick_mem [0:PICKS-1];
    logic                 pick_rd_reg;
    logic                 desc_reg, desc_next;
    logic                 empty_run_reg, empty_run_next;
    logic                 m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]    m_data_reg, m_data_next;
    logic                 m_last_reg, m_last_next;
    logic                 m_empty_reg, m_empty_next;
    logic                 m_ovf_reg, m_ovf_next;

    logic                 accept;
    logic                 emit_phase;
    logic [CNT_W-1:0]     rd_a_full;
    logic [CNT_W-1:0]     rd_b_full;
    logic                 a_left;
    logic                 b_left;
    logic                 take_a;
    logic                 cur_from_a;
    logic                 out_free;
    logic [VALUE_WIDTH-1:0] sel_data;

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign emit_phase = (state_reg == ST_EMIT_RD) || (state_reg == ST_EMIT_OUT);

    assign rd_a_full = (emit_phase && desc_reg) ? ia_reg - CNT_W'(1) : ia_reg;
    assign rd_b_full = (emit_phase && desc_reg) ? ib_reg - CNT_W'(1) : ib_reg;
    assign rd_addr_a = rd_a_full[IDX_W-1:0];
    assign rd_addr_b = rd_b_full[IDX_W-1:0];

    assign wr_data = VALUE_WIDTH'($signed(s_tdata));

    assign a_left     = (ia_reg < cnt_a_reg);
    assign b_left     = (ib_reg < cnt_b_reg);
    assign take_a     = a_left && (!b_left || ($signed(rd_data_a) < $signed(rd_data_b)));
    assign cur_from_a = pick_rd_reg;
    assign sel_data   = cur_from_a ? rd_data_a : rd_data_b;
    assign out_free   = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = {m_ovf_reg, m_empty_reg};

    always_comb begin
        state_next     = state_reg;
        cnt_a_next     = cnt_a_reg;
        cnt_b_next     = cnt_b_reg;
        ovf_next       = ovf_reg;
        ia_next        = ia_reg;
        ib_next        = ib_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        desc_next      = desc_reg;
        empty_run_next = empty_run_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_last_next    = m_last_reg;
        m_empty_next   = m_empty_reg;
        m_ovf_next     = m_ovf_reg;
        wr_strobe      = '0;
        wr_addr        = cnt_a_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_tuser)
                        OP_APPEND_A: begin
                            wr_addr = cnt_a_reg[IDX_W-1:0];
                            if (cnt_a_reg < CNT_W'(LIST_DEPTH)) begin
                                wr_strobe.we_a = 1'b1;
                                cnt_a_next     = cnt_a_reg + CNT_W'(1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        OP_APPEND_B: begin
                            wr_addr = cnt_b_reg[IDX_W-1:0];
                            if (cnt_b_reg < CNT_W'(LIST_DEPTH)) begin
                                wr_strobe.we_b = 1'b1;
                                cnt_b_next     = cnt_b_reg + CNT_W'(1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        OP_MERGE_ASC, OP_MERGE_DSC: begin
                            desc_next = (s_tuser == OP_MERGE_DSC);
                            ia_next   = '0;
                            ib_next   = '0;
                            k_next    = '0;
                            n_next    = STEP_W'(cnt_a_reg) + STEP_W'(cnt_b_reg);
                            if ((cnt_a_reg == '0) && (cnt_b_reg == '0)) begin
                                empty_run_next = 1'b1;
                                state_next     = ST_EMIT_OUT;
                            end else begin
                                empty_run_next = 1'b0;
                                state_next     = ST_SCAN_RD;
                            end
                        end
                        OP_CLEAR: begin
                            cnt_a_next = '0;
                            cnt_b_next = '0;
                            ovf_next   = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN_RD: begin
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                if (take_a) begin
                    ia_next = ia_reg + CNT_W'(1);
                end else begin
                    ib_next = ib_reg + CNT_W'(1);
                end
                if (k_reg + STEP_W'(1) == n_reg) begin
                    state_next = ST_EMIT_RD;
                    if (!desc_reg) begin
                        ia_next = '0;
                        ib_next = '0;
                        k_next  = '0;
                    end
                end else begin
                    k_next     = k_reg + STEP_W'(1);
                    state_next = ST_SCAN_RD;
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_ovf_next   = ovf_reg;
                    m_empty_next = empty_run_reg;
                    if (empty_run_reg) begin
                        m_data_next = '0;
                        m_last_next = 1'b1;
                        state_next  = ST_IDLE;
                    end else begin
                        m_data_next = DATA_W'($unsigned(sel_data));
                        if (desc_reg) begin
                            m_last_next = (k_reg == '0);
                            k_next      = k_reg - STEP_W'(1);
                            if (cur_from_a) begin
                                ia_next = ia_reg - CNT_W'(1);
                            end else begin
                                ib_next = ib_reg - CNT_W'(1);
                            end
                        end else begin
                            m_last_next = (k_reg + STEP_W'(1) == n_reg);
                            k_next      = k_reg + STEP_W'(1);
                            if (cur_from_a) begin
                                ia_next = ia_reg + CNT_W'(1);
                            end else begin
                                ib_next = ib_reg + CNT_W'(1);
                            end
                        end
                        state_next = m_last_next ? ST_IDLE : ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_a_reg   <= '0;
            cnt_b_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_a_reg   <= cnt_a_next;
            cnt_b_reg   <= cnt_b_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_SCAN_CMP) begin
            pick_mem[k_reg[PICK_W-1:0]] <= take_a;
        end
        pick_rd_reg   <= pick_mem[k_reg[PICK_W-1:0]];
        ia_reg        <= ia_next;
        ib_reg        <= ib_next;
        k_reg         <= k_next;
        n_reg         <= n_next;
        desc_reg      <= desc_next;
        empty_run_reg <= empty_run_next;
        m_data_reg    <= m_data_next;
        m_last_reg    <= m_last_next;
        m_empty_reg   <= m_empty_next;
        m_ovf_reg     <= m_ovf_next;
    end

endmodule

// ----- src/sorted_list_merger_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_list_merger_unit: two-way merge of two stored lists
// Appends and clears are handled in the idle state. A merge of n stored values
// first runs a compare pass with a read state and a compare state per value,
// limited by the registered read port of each list store feeding the single
// signed comparator, and then emits each beat through a read state and an
// output state, holding while the output side stalls. The input is ready again
// in the cycle in which the last beat is presented; a merge of two empty lists
// presents one marker beat from the output state. The input is not ready while a
// merge runs. The lists remain stored after a merge, and the merged beats are
// the ascending merge, or its exact reverse for the descending command.
// ----------------------------------------------------------------------------
module sorted_list_merger_unit
    import slm_pkg::*;
#(
    parameter int LIST_DEPTH  = LIST_DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // value_in
    input  logic [OP_W-1:0]   s_tuser,   // operation
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // value_out
    output logic              m_tlast,
    output logic [1:0]        m_tuser    // overflowed, empty_res
);

    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    slm_wr_t                wr_strobe;
    logic [IDX_W-1:0]       wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic [IDX_W-1:0]       rd_addr_a;
    logic [IDX_W-1:0]       rd_addr_b;
    logic [VALUE_WIDTH-1:0] rd_data_a;
    logic [VALUE_WIDTH-1:0] rd_data_b;

    slm_merge_ctrl #(
        .LIST_DEPTH  (LIST_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .wr_strobe (wr_strobe),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    slm_list_mem #(
        .DEPTH (LIST_DEPTH),
        .WIDTH (VALUE_WIDTH),
        .IDX_W (IDX_W)
    ) u_list_a (
        .aclk    (aclk),
        .wr_en   (wr_strobe.we_a),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr_a),
        .rd_data (rd_data_a)
    );

    slm_list_mem #(
        .DEPTH (LIST_DEPTH),
        .WIDTH (VALUE_WIDTH),
        .IDX_W (IDX_W)
    ) u_list_b (
        .aclk    (aclk),
        .wr_en   (wr_strobe.we_b),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr_b),
        .rd_data (rd_data_b)
    );

endmodule

// ----- dv/tb_sorted_list_merger_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_list_merger_unit: self-checking bench for the sorted list merger
// Commands are driven over the input stream in random bursts while the output
// side stalls in changing patterns. A predictor keeps its own copy of both
// lists and of the sticky overflow flag, and queues the merged beats that each
// accepted merge command must produce. Every output beat is compared with the
// oldest queued beat. The run covers directed corner cases, full lists with
// dropped appends, and a long series of random load-and-merge sequences.
// ----------------------------------------------------------------------------
module tb_sorted_list_merger_unit;
    import slm_pkg::*;

    localparam int                LIST_DEPTH     = LIST_DEPTH_DEF;
    localparam int                WATCHDOG_LIMIT = 2000;
    localparam int                TOTAL_ITEMS    = 380;
    localparam int                MAX_REPORTS    = 10;
    localparam logic [OP_W-1:0]   OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0]   OP_SPARE_LAST  = 3'd7;
    localparam logic [DATA_W-1:0] VAL_MIN        = 32'h8000_0000;
    localparam logic [DATA_W-1:0] VAL_MAX        = 32'h7fff_ffff;

    typedef struct {
        logic [DATA_W-1:0] value;
        logic              last;
        logic              empty_res;
        logic              overflowed;
    } merge_beat_t;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;
    typedef enum int {STYLE_SORTED, STYLE_TIES, STYLE_WIDE} value_style_e;

    logic              aclk;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;  // value_in
    logic [OP_W-1:0]   s_tuser  = '0;  // operation
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;        // value_out
    logic              m_tlast;
    logic [1:0]        m_tuser;        // overflowed, empty_res

    logic signed [DATA_W-1:0] held_a [LIST_DEPTH];
    logic signed [DATA_W-1:0] held_b [LIST_DEPTH];
    int                       held_a_count;
    int                       held_b_count;
    bit                       dropped_flag;
    merge_beat_t              pending_merge_beats [$];

    int       mismatch_count;
    int       idle_cycles;
    int       sent_items;
    int       burst_left;
    bit       gaps_on = 1'b1;
    bit       drive_active;
    rx_mode_e ready_mode;
    int       ready_span;

    sorted_list_merger_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    task automatic apply_command(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value);
        logic signed [DATA_W-1:0] merged [$];
        merge_beat_t              beat;
        int                       ia;
        int                       ib;
        int                       n;
        ia = 0;
        ib = 0;
        case (op)
            OP_APPEND_A: begin
                if (held_a_count < LIST_DEPTH) begin
                    held_a[held_a_count] = value;
                    held_a_count++;
                end else begin
                    dropped_flag = 1'b1;
                end
            end
            OP_APPEND_B: begin
                if (held_b_count < LIST_DEPTH) begin
                    held_b[held_b_count] = value;
                    held_b_count++;
                end else begin
                    dropped_flag = 1'b1;
                end
            end
            OP_CLEAR: begin
                held_a_count = 0;
                held_b_count = 0;
                dropped_flag = 1'b0;
            end
            OP_MERGE_ASC, OP_MERGE_DSC: begin
                if (held_a_count == 0 && held_b_count == 0) begin
                    beat.value      = '0;
                    beat.last       = 1'b1;
                    beat.empty_res  = 1'b1;
                    beat.overflowed = dropped_flag;
                    pending_merge_beats.push_back(beat);
                end else begin
                    // On equal heads the B element goes first.
                    while (ia < held_a_count && ib < held_b_count) begin
                        if (held_a[ia] < held_b[ib]) begin
                            merged.push_back(held_a[ia]);
                            ia++;
                        end else begin
                            merged.push_back(held_b[ib]);
                            ib++;
                        end
                    end
                    while (ia < held_a_count) begin
                        merged.push_back(held_a[ia]);
                        ia++;
                    end
                    while (ib < held_b_count) begin
                        merged.push_back(held_b[ib]);
                        ib++;
                    end
                    n = merged.size();
                    for (int k = 0; k < n; k++) begin
                        beat.value      = (op == OP_MERGE_DSC) ? merged[n - 1 - k] : merged[k];
                        beat.last       = (k == n - 1);
                        beat.empty_res  = 1'b0;
                        beat.overflowed = dropped_flag;
                        pending_merge_beats.push_back(beat);
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_command(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = gaps_on ? $urandom_range(0, 5) : 0;
            if (gap > 0 && drive_active) begin
                s_tvalid     <= 1'b0;
                drive_active = 1'b0;
            end
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid     <= 1'b1;
        s_tdata      <= value;
        s_tuser      <= op;
        drive_active = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        sent_items++;
        apply_command(op, value);
    endtask

    task automatic wait_all_results();
        if (drive_active) begin
            s_tvalid     <= 1'b0;
            drive_active = 1'b0;
        end
        burst_left = 0;
        @(posedge aclk);
        while (pending_merge_beats.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return VAL_MIN;
                    1:       return VAL_MAX;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            1:       return $urandom_range(0, 8) - 4;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] next_value(input value_style_e style,
                                                     input logic [DATA_W-1:0] prev);
        case (style)
            STYLE_SORTED: return prev + $urandom_range(0, 3);
            STYLE_TIES:   return $urandom_range(0, 6) - 3;
            default:      return pick_value();
        endcase
    endfunction

    function automatic int list_size();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(LIST_DEPTH - 2, LIST_DEPTH + 2);
            1, 2:    return $urandom_range(7, 20);
            default: return $urandom_range(0, 6);
        endcase
    endfunction

    task automatic test_directed();
        send_command(OP_MERGE_ASC, '0);
        send_command(OP_MERGE_DSC, '0);
        for (logic [OP_W:0] op = {1'b0, OP_SPARE_FIRST}; op <= {1'b0, OP_SPARE_LAST}; op++) begin
            send_command(op[OP_W-1:0], '1);
        end
        send_command(OP_APPEND_A, VAL_MIN);
        send_command(OP_APPEND_A, '1);
        send_command(OP_APPEND_A, '0);
        send_command(OP_APPEND_A, VAL_MAX);
        send_command(OP_APPEND_B, VAL_MIN);
        send_command(OP_APPEND_B, '0);
        send_command(OP_APPEND_B, 32'd1);
        send_command(OP_APPEND_B, VAL_MAX);
        send_command(OP_MERGE_ASC, '0);
        send_command(OP_MERGE_DSC, '0);
        send_command(OP_CLEAR, '0);
        send_command(OP_APPEND_B, 32'd5);
        send_command(OP_MERGE_ASC, '0);
        send_command(OP_CLEAR, '0);
        send_command(OP_APPEND_A, 32'd7);
        send_command(OP_APPEND_A, -32'sd7);
        send_command(OP_MERGE_DSC, '0);
        send_command(OP_CLEAR, '0);
        send_command(OP_MERGE_ASC, '0);
    endtask

    task automatic test_full_lists();
        send_command(OP_CLEAR, '0);
        repeat (LIST_DEPTH + 1) send_command(OP_APPEND_A, pick_value());
        send_command(OP_MERGE_ASC, '0);
        repeat (LIST_DEPTH + 1) send_command(OP_APPEND_B, pick_value());
        send_command(OP_MERGE_ASC, '0);
        wait_all_results();
        send_command(OP_MERGE_DSC, '0);
        send_command(OP_APPEND_A, VAL_MAX);
        send_command(OP_CLEAR, '0);
        send_command(OP_MERGE_ASC, '0);
    endtask

    task automatic test_random_sequences();
        int                kind;
        int                na;
        int                nb;
        value_style_e      style;
        logic [DATA_W-1:0] va;
        logic [DATA_W-1:0] vb;
        while (sent_items < TOTAL_ITEMS) begin
            kind = $urandom_range(0, 19);
            if (kind < 14) begin
                if (kind < 11) begin
                    send_command(OP_CLEAR, $urandom);
                end
                na    = list_size();
                nb    = list_size();
                style = value_style_e'($urandom_range(STYLE_SORTED, STYLE_WIDE));
                va    = pick_value();
                vb    = (style == STYLE_SORTED) ? va : pick_value();
                while (na > 0 || nb > 0) begin
                    if (na > 0 && (nb == 0 || $urandom_range(0, 1))) begin
                        send_command(OP_APPEND_A, va);
                        va = next_value(style, va);
                        na--;
                    end else begin
                        send_command(OP_APPEND_B, vb);
                        vb = next_value(style, vb);
                        nb--;
                    end
                end
                repeat ($urandom_range(1, 2)) begin
                    send_command($urandom_range(0, 1) ? OP_MERGE_ASC : OP_MERGE_DSC, $urandom);
                end
            end else if (kind < 17) begin
                repeat ($urandom_range(1, 4)) begin
                    send_command(OP_W'($urandom_range(OP_APPEND_A, OP_SPARE_LAST)),
                                 pick_value());
                end
            end else if (kind == 17) begin
                send_command($urandom_range(0, 1) ? OP_MERGE_ASC : OP_MERGE_DSC, $urandom);
            end else if (kind == 18) begin
                gaps_on = !gaps_on;
            end else begin
                wait_all_results();
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            ready_span = 0;
        end else begin
            if (ready_span == 0) begin
                ready_mode = rx_mode_e'($urandom_range(RX_ALWAYS, RX_PERIODIC));
                ready_span = $urandom_range(10, 150);
            end
            ready_span--;
            case (ready_mode)
                RX_ALWAYS: m_tready <= 1'b1;
                RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:   m_tready <= (ready_span % 3 != 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        merge_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_merge_beats.size() == 0) begin
                if (mismatch_count < MAX_REPORTS) begin
                    $display("unexpected beat: data %h last %b empty %b overflow %b",
                             m_tdata, m_tlast, m_tuser[0], m_tuser[1]);
                end
                mismatch_count++;
            end else begin
                want = pending_merge_beats.pop_front();
                if (m_tlast !== want.last || m_tuser[0] !== want.empty_res ||
                    m_tuser[1] !== want.overflowed ||
                    (!want.empty_res && m_tdata !== want.value)) begin
                    if (mismatch_count < MAX_REPORTS) begin
                        $display("beat mismatch: expected data %h last %b empty %b overflow %b",
                                 want.value, want.last, want.empty_res, want.overflowed);
                        $display("               actual   data %h last %b empty %b overflow %b",
                                 m_tdata, m_tlast, m_tuser[0], m_tuser[1]);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_sorted_list_merger_unit failed");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_full_lists();
        test_random_sequences();
        wait_all_results();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb_sorted_list_merger_unit passed");
        end else begin
            $display("tb_sorted_list_merger_unit failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/slm_pkg.sv
src/slm_list_mem.sv
src/slm_merge_ctrl.sv
src/sorted_list_merger_unit.sv
dv/tb_sorted_list_merger_unit.sv
